// File: design/lgq_pkg.sv
// Shared types, constants and configuration helpers for the LOD grid quad index generator.
`default_nettype none

package lgq_pkg;

    localparam int MAX_SIZE_LOG2 = 8;
    localparam int COORD_W       = MAX_SIZE_LOG2 + 1;
    localparam int WIDE_W        = MAX_SIZE_LOG2 + 2;
    localparam int STRIPE_W      = MAX_SIZE_LOG2;
    localparam int INDEX_W       = 17;
    localparam int CORNER_W      = 3;
    localparam int CFG_INDEX_W   = 4;
    localparam int CFG_DATA_W    = 4;
    localparam int LOG_W         = 4;

    localparam logic [CFG_INDEX_W-1:0] REG_GRID_SIZE_LOG2 = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STRIPE_LOG2    = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_LOD_LEVEL      = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SKIRT_MODE     = 4'd3;

    localparam logic [LOG_W-1:0] GRID_SIZE_LOG2_RESET = 4'd6;
    localparam logic [LOG_W-1:0] STRIPE_LOG2_RESET    = 4'd3;
    localparam logic [LOG_W-1:0] LOD_LEVEL_RESET      = 4'd0;

    localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd5;

    // Effective walk configuration after saturation.
    typedef struct packed {
        logic [LOG_W-1:0] size_log2;
        logic [LOG_W-1:0] lod;
        logic [LOG_W-1:0] interval_log2;
        logic             skirt;
    } walk_cfg_t;

    // One quad as handed from the front end to the back end.
    typedef struct packed {
        logic [COORD_W-1:0] rp;
        logic [COORD_W-1:0] cp;
        logic [COORD_W-1:0] dr;
        logic [COORD_W-1:0] dc;
        logic               final_quad;
    } quad_t;

    function automatic walk_cfg_t make_walk_cfg(
        input logic [LOG_W-1:0] grid_size_log2,
        input logic [LOG_W-1:0] stripe_log2,
        input logic [LOG_W-1:0] lod_level,
        input logic             skirt_mode
    );
        walk_cfg_t        c;
        logic [LOG_W-1:0] g;
        logic [LOG_W-1:0] l;
        logic [LOG_W:0]   il;
        g = grid_size_log2;
        if (g < LOG_W'(1)) g = LOG_W'(1);
        if (g > LOG_W'(MAX_SIZE_LOG2)) g = LOG_W'(MAX_SIZE_LOG2);
        l = (lod_level > g) ? g : lod_level;
        il = {1'b0, stripe_log2} + {1'b0, l};
        if (il > {1'b0, g}) il = {1'b0, g};
        c.size_log2     = g;
        c.lod           = l;
        c.interval_log2 = il[LOG_W-1:0];
        c.skirt         = skirt_mode;
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/lgq_front.sv
// Front end: accepts walk requests, tracks the walk position and emits one quad per request.
`default_nettype none

module lgq_front (
    input  wire                    clk,
    input  wire                    rst_n,
    input  lgq_pkg::walk_cfg_t     cfg,
    input  wire                    walk_home,
    input  wire                    take,
    input  wire                    restart,
    output lgq_pkg::quad_t         quad
);
    import lgq_pkg::*;

    logic [STRIPE_W-1:0] stripe_reg, stripe_next;
    logic                edge_reg, edge_next;
    logic [COORD_W-1:0]  row_reg, row_next;
    logic [COORD_W-1:0]  col_reg, col_next;

    logic [STRIPE_W-1:0] cur_stripe;
    logic                cur_edge;
    logic [COORD_W-1:0]  cur_row;
    logic [COORD_W-1:0]  cur_col;

    logic [WIDE_W-1:0] size_w, delta_w, nstripes_w;
    logic [WIDE_W-1:0] limit_w, base_w, stripe_inc_w;
    logic [WIDE_W-1:0] col_adv, row_adv, pos, pos_adv;
    logic              side, side_n, edge_n;

    always_comb
    begin
        cur_stripe = restart ? '0 : stripe_reg;
        cur_edge   = restart ? 1'b0 : edge_reg;
        cur_row    = restart ? '0 : row_reg;
        cur_col    = restart ? '0 : col_reg;

        size_w       = WIDE_W'(1) << cfg.size_log2;
        delta_w      = WIDE_W'(1) << cfg.lod;
        nstripes_w   = WIDE_W'(1) << (cfg.size_log2 - cfg.interval_log2);
        stripe_inc_w = {2'b00, cur_stripe} + WIDE_W'(1);
        limit_w      = stripe_inc_w << cfg.interval_log2;
        base_w       = {2'b00, cur_stripe} << cfg.interval_log2;

        side    = cur_stripe[0];
        pos     = side ? {1'b0, cur_row} : {1'b0, cur_col};
        pos_adv = pos + delta_w;
        col_adv = {1'b0, cur_col} + delta_w;
        row_adv = {1'b0, cur_row} + delta_w;
        side_n  = side;
        edge_n  = cur_edge;

        quad = '0;
        stripe_next = cur_stripe;
        edge_next   = cur_edge;
        row_next    = cur_row;
        col_next    = cur_col;

        if (!cfg.skirt)
        begin
            quad.rp = cur_row + COORD_W'(1);
            quad.cp = cur_col + COORD_W'(1);
            quad.dr = delta_w[COORD_W-1:0];
            quad.dc = delta_w[COORD_W-1:0];
            quad.final_quad = ({2'b00, cur_stripe} == nstripes_w - WIDE_W'(1)) &&
                              ({1'b0, cur_row} == size_w - delta_w) &&
                              ({1'b0, cur_col} == size_w - delta_w);
            // Column steps inside the stripe, then rows, then the next stripe.
            if (col_adv >= limit_w)
            begin
                if (row_adv >= size_w)
                begin
                    row_next = '0;
                    if (stripe_inc_w >= nstripes_w)
                    begin
                        stripe_next = '0;
                        col_next    = '0;
                    end
                    else
                    begin
                        stripe_next = stripe_inc_w[STRIPE_W-1:0];
                        col_next    = limit_w[COORD_W-1:0];
                    end
                end
                else
                begin
                    row_next = row_adv[COORD_W-1:0];
                    col_next = base_w[COORD_W-1:0];
                end
            end
            else
            begin
                col_next = col_adv[COORD_W-1:0];
            end
        end
        else
        begin
            if (!side)
            begin
                quad.rp = cur_edge ? size_w[COORD_W-1:0] + COORD_W'(1) : '0;
                quad.cp = pos[COORD_W-1:0] + COORD_W'(1);
                quad.dr = COORD_W'(1);
                quad.dc = delta_w[COORD_W-1:0];
            end
            else
            begin
                quad.rp = pos[COORD_W-1:0] + COORD_W'(1);
                quad.cp = cur_edge ? size_w[COORD_W-1:0] + COORD_W'(1) : '0;
                quad.dr = delta_w[COORD_W-1:0];
                quad.dc = COORD_W'(1);
            end
            quad.final_quad = side && cur_edge && (pos == size_w - delta_w);
            if (pos_adv >= size_w)
            begin
                pos_adv = '0;
                edge_n  = ~cur_edge;
                if (cur_edge)
                begin
                    side_n = ~side;
                end
            end
            stripe_next = {{(STRIPE_W-1){1'b0}}, side_n};
            edge_next   = edge_n;
            row_next    = side_n ? pos_adv[COORD_W-1:0] : '0;
            col_next    = side_n ? '0 : pos_adv[COORD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stripe_reg <= '0;
            edge_reg   <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else if (walk_home)
        begin
            stripe_reg <= '0;
            edge_reg   <= 1'b0;
            row_reg    <= '0;
            col_reg    <= '0;
        end
        else if (take)
        begin
            stripe_reg <= stripe_next;
            edge_reg   <= edge_next;
            row_reg    <= row_next;
            col_reg    <= col_next;
        end
    end

endmodule

`default_nettype wire

// File: design/lgq_queue.sv
// Two-entry quad queue between the front end and the back end.
`default_nettype none

module lgq_queue (
    input  wire             clk,
    input  wire             rst_n,
    input  wire             push,
    input  lgq_pkg::quad_t  push_quad,
    input  wire             pop,
    output logic            full,
    output logic            not_empty,
    output lgq_pkg::quad_t  head
);
    import lgq_pkg::*;

    quad_t       entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg, count_next;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_quad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: design/lgq_back.sv
// Back end: expands each queued quad into six registered vertex indices.
`default_nettype none

module lgq_back (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire [lgq_pkg::LOG_W-1:0]       size_log2,
    input  wire                            quad_valid,
    input  lgq_pkg::quad_t                 quad,
    output logic                           quad_pop,
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic [lgq_pkg::INDEX_W-1:0]    vertex_index,
    output logic [lgq_pkg::CORNER_W-1:0]   corner,
    output logic                           last_of_quad,
    output logic                           end_of_buffer
);
    import lgq_pkg::*;

    logic [CORNER_W-1:0] k_reg;
    logic                valid_reg;
    logic [INDEX_W-1:0]  index_reg, index_next;
    logic [CORNER_W-1:0] corner_reg;
    logic                last_reg, end_reg;
    logic                load;
    logic [COORD_W-1:0]  pr, pc, pr_far, pc_far;

    assign load     = quad_valid && (!valid_reg || !out_stall);
    assign quad_pop = load && (k_reg == LAST_CORNER);

    always_comb
    begin
        pr_far = quad.rp + quad.dr;
        pc_far = quad.cp + quad.dc;
        case (k_reg)
            3'd0:    begin pr = quad.rp; pc = quad.cp; end
            3'd1:    begin pr = pr_far;  pc = quad.cp; end
            3'd2:    begin pr = pr_far;  pc = pc_far;  end
            3'd3:    begin pr = pr_far;  pc = pc_far;  end
            3'd4:    begin pr = quad.rp; pc = pc_far;  end
            default: begin pr = quad.rp; pc = quad.cp; end
        endcase
        // row * (size + 3) + col, with size a power of two.
        index_next = (INDEX_W'(pr) << size_log2) + (INDEX_W'(pr) << 1) +
                     INDEX_W'(pr) + INDEX_W'(pc);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            index_reg  <= index_next;
            corner_reg <= k_reg;
            last_reg   <= (k_reg == LAST_CORNER);
            end_reg    <= (k_reg == LAST_CORNER) && quad.final_quad;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                k_reg     <= (k_reg == LAST_CORNER) ? '0 : k_reg + CORNER_W'(1);
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = valid_reg;
    assign vertex_index  = index_reg;
    assign corner        = corner_reg;
    assign last_of_quad  = last_reg;
    assign end_of_buffer = end_reg;

endmodule

`default_nettype wire

// File: design/lod_grid_quad_index_generator_unit.sv
// Top level of the LOD grid quad index generator: configuration registers and the front/back split.
// The first index of a request is held in a quad queue entry and then in the back end's output register.
// Each request (one quad) yields six indices; the back end emits one index per cycle while out_stall is low.
// The front end takes a request whenever its two-entry quad queue has room.
// Reset: configuration returns to grid 2^6, stripe 2^3, lod 0, patch mode; the walk starts at
// its first quad, the queue is empty and no result is pending.
`default_nettype none

module lod_grid_quad_index_generator_unit (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                cfg_valid,
    output logic                               cfg_ready,
    input  wire [lgq_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire [lgq_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire                                in_valid,
    output logic                               in_stall,
    input  wire                                restart,
    output logic                               out_valid,
    input  wire                                out_stall,
    output logic [lgq_pkg::INDEX_W-1:0]        vertex_index,
    output logic [lgq_pkg::CORNER_W-1:0]       corner,
    output logic                               last_of_quad,
    output logic                               end_of_buffer
);
    import lgq_pkg::*;

    // Raw configuration registers, as written.
    logic [LOG_W-1:0] grid_size_log2_reg;
    logic [LOG_W-1:0] stripe_log2_reg;
    logic [LOG_W-1:0] lod_level_reg;
    logic             skirt_mode_reg;

    logic      cfg_write;
    logic      cfg_hit;
    walk_cfg_t walk_cfg;
    logic      in_take;
    quad_t     front_quad;
    quad_t     head_quad;
    logic      queue_full;
    logic      queue_not_empty;
    logic      queue_pop;

    // Configuration writes are to be made only while idle (the block does not enforce this); the port is always open.
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    // A write to any existing register puts the walk back at its first quad; writes to
    // indexes beyond the register list are dropped.
    assign cfg_hit = cfg_write && ((cfg_index == REG_GRID_SIZE_LOG2) ||
                                   (cfg_index == REG_STRIPE_LOG2) ||
                                   (cfg_index == REG_LOD_LEVEL) ||
                                   (cfg_index == REG_SKIRT_MODE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_log2_reg <= GRID_SIZE_LOG2_RESET;
            stripe_log2_reg    <= STRIPE_LOG2_RESET;
            lod_level_reg      <= LOD_LEVEL_RESET;
            skirt_mode_reg     <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GRID_SIZE_LOG2: grid_size_log2_reg <= cfg_data[LOG_W-1:0];
                REG_STRIPE_LOG2:    stripe_log2_reg    <= cfg_data[LOG_W-1:0];
                REG_LOD_LEVEL:      lod_level_reg      <= cfg_data[LOG_W-1:0];
                REG_SKIRT_MODE:     skirt_mode_reg     <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // Saturated grid size, lod and stripe interval, shared by both halves.
    assign walk_cfg = make_walk_cfg(grid_size_log2_reg, stripe_log2_reg,
                                    lod_level_reg, skirt_mode_reg);

    // A request is taken whenever the quad queue has a free entry, independent of
    // whether the back end is currently stalled by the result channel.
    assign in_stall = queue_full;
    assign in_take  = in_valid && !in_stall;

    lgq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (walk_cfg),
        .walk_home (cfg_hit),
        .take      (in_take),
        .restart   (restart),
        .quad      (front_quad)
    );

    lgq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_take),
        .push_quad (front_quad),
        .pop       (queue_pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head      (head_quad)
    );

    // The back end drains one quad as six results, holding its output register
    // while the result channel stalls.
    lgq_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .size_log2     (walk_cfg.size_log2),
        .quad_valid    (queue_not_empty),
        .quad          (head_quad),
        .quad_pop      (queue_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .vertex_index  (vertex_index),
        .corner        (corner),
        .last_of_quad  (last_of_quad),
        .end_of_buffer (end_of_buffer)
    );

endmodule

`default_nettype wire
